// ===== sv/tfn_pkg.sv =====
// Shared types and constants for the triangle face normal unit.
// No dependencies; imported by triangle_face_normal_unit.
package tfn_pkg;

    // Default table depths.
    localparam int unsigned VERTEX_DEPTH_DEF = 4096;
    localparam int unsigned FACE_DEPTH_DEF   = 4096;

    // Field widths.
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned OUT_W   = 16;

    // Index compare width, enough for any slot, count or depth up to 2^20.
    localparam int unsigned IDX_W = 21;

    // Datapath widths.
    localparam int unsigned EDGE_W  = COORD_W + 1;
    localparam int unsigned PROD_W  = 2 * EDGE_W;
    localparam int unsigned MAG_W   = PROD_W + 1;
    localparam int unsigned NORM_W  = 30;
    localparam int unsigned SQ_W    = 2 * NORM_W;
    localparam int unsigned SUM_W   = SQ_W + 2;
    localparam int unsigned ROOT_W  = SUM_W / 2;
    localparam int unsigned QFRAC   = 14;
    localparam int unsigned QUO_W   = QFRAC + 1;
    localparam int unsigned NUM_W   = NORM_W + QFRAC + 1;
    localparam int unsigned SH_N    = MAG_W - NORM_W;
    localparam int unsigned SH_W    = $clog2(SH_N + 1);

    // Iteration counts of the root and divide pipelines.
    localparam int unsigned SQRT_STEPS = ROOT_W;
    localparam int unsigned DIV_STEPS  = QUO_W;

    // Configuration port.
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_FACE_COUNT   = 1'b1;

    // Request codes.
    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_FACE   = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [SLOT_W-1:0]         entry_slot;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [SLOT_W-1:0]         corner_a;
        logic [SLOT_W-1:0]         corner_b;
        logic [SLOT_W-1:0]         corner_c;
    } req_word_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
        logic                    index_error;
    } rsp_word_t;

endpackage

// ===== sv/triangle_face_normal_unit.sv =====
// Triangle face normal unit: vertex and face tables with a pipelined
// cross product, square root and divide. Depends on tfn_pkg.
//
// The unit takes one word per clock while req_stall is low. Vertex and
// face writes produce no result. A normal query produces one result.
// The stages are a face table read, and a vertex table read that uses three
// copies of the vertex table so the three corners are read at once. Then
// come eight arithmetic stages, a 31-stage square root, one rounding stage,
// a 15-stage divider with one quotient bit per stage, and the output
// register. Results leave through a two-entry output buffer. req_stall rises
// only when both entries hold, and the whole pipeline then holds in place.
// Writes and queries pass the tables in order, so a query sees every write
// accepted before it. The tables have no reset.
module triangle_face_normal_unit
    import tfn_pkg::*;
#(
    parameter int unsigned VERTEX_DEPTH = VERTEX_DEPTH_DEF,
    parameter int unsigned FACE_DEPTH   = FACE_DEPTH_DEF
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  req_word_t          req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_word_t          rsp_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int unsigned VA_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int unsigned FA_W = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
    localparam int unsigned VW_W = 3 * COORD_W;
    localparam int unsigned FW_W = 3 * SLOT_W;

    typedef struct packed {
        logic       query;
        logic       idx_err;
        logic       degen;
        logic [2:0] neg;
    } flags_t;

    typedef logic [2:0][NORM_W-1:0] mg_vec_t;

    function automatic logic signed [EDGE_W-1:0] coord_ext(
        input logic [VW_W-1:0] w,
        input int unsigned     i
    );
        logic [COORD_W-1:0] c;
        c = w[(3 - i) * COORD_W - 1 -: COORD_W];
        return $signed({c[COORD_W-1], c});
    endfunction

    function automatic logic corner_ok(
        input logic [IDX_W-1:0]   idx,
        input logic [COUNT_W-1:0] cnt
    );
        return (idx < IDX_W'(VERTEX_DEPTH)) && (idx < IDX_W'(cnt));
    endfunction

    logic en, accept, cfg_wr, emit;
    logic [COUNT_W-1:0] vertex_count_reg, face_count_reg;

    logic               skid_valid_reg, out_valid_reg;
    logic               skid_valid_next, out_valid_next;
    rsp_word_t          skid_reg, out_reg, skid_next, out_next, fin_word;

    // The pipeline moves whenever the spare output entry is free.
    assign en        = !skid_valid_reg;
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && en;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
            face_count_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[PADDR_W-1])
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[COUNT_W-1:0];
                REG_FACE_COUNT:   face_count_reg   <= pwdata[COUNT_W-1:0];
                default:          vertex_count_reg <= vertex_count_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[PADDR_W-1])
            REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count_reg);
            REG_FACE_COUNT:   prdata = PDATA_W'(face_count_reg);
            default:          prdata = '0;
        endcase
    end

    // Stage 1: face table write or read, range check of the face slot.
    logic [IDX_W-1:0] slot_ext;
    logic             slot_in_face, face_ok0;
    logic [FW_W-1:0]  face_mem [FACE_DEPTH];
    logic [FW_W-1:0]  face_rd_reg;
    logic [8:0]       vld_reg;
    logic [1:0]       s1_req_reg;
    logic [IDX_W-1:0] s1_slot_reg;
    logic [VW_W-1:0]  s1_coord_reg;
    logic             s1_face_ok_reg;

    assign slot_ext     = IDX_W'(req_word.entry_slot);
    assign slot_in_face = slot_ext < IDX_W'(FACE_DEPTH);
    assign face_ok0     = slot_in_face && (slot_ext < IDX_W'(face_count_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept && (req_word.req_type == REQ_FACE) && slot_in_face)
            begin
                face_mem[slot_ext[FA_W-1:0]] <= {req_word.corner_a, req_word.corner_b,
                                                 req_word.corner_c};
            end
            face_rd_reg    <= face_mem[slot_ext[FA_W-1:0]];
            s1_req_reg     <= req_word.req_type;
            s1_slot_reg    <= slot_ext;
            s1_coord_reg   <= {req_word.coord_x, req_word.coord_y, req_word.coord_z};
            s1_face_ok_reg <= face_ok0;
        end
    end

    // Valid bits of the front stages, one per stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:0], accept};
        end
    end

    // Stage 2: vertex table write or three corner reads, corner checks.
    logic [IDX_W-1:0] ca, cb, cc;
    logic             vert_wr;
    logic [VW_W-1:0]  vert_mem_a [VERTEX_DEPTH];
    logic [VW_W-1:0]  vert_mem_b [VERTEX_DEPTH];
    logic [VW_W-1:0]  vert_mem_c [VERTEX_DEPTH];
    logic [VW_W-1:0]  rd_a_reg, rd_b_reg, rd_c_reg;
    flags_t           flg_reg [2:9];
    flags_t           flg2_next, flg6_next;

    assign ca = IDX_W'(face_rd_reg[FW_W-1 -: SLOT_W]);
    assign cb = IDX_W'(face_rd_reg[FW_W-SLOT_W-1 -: SLOT_W]);
    assign cc = IDX_W'(face_rd_reg[SLOT_W-1:0]);
    assign vert_wr = en && vld_reg[0] && (s1_req_reg == REQ_VERTEX)
                     && (s1_slot_reg < IDX_W'(VERTEX_DEPTH));

    always_ff @(posedge clk)
    begin
        if (vert_wr)
        begin
            vert_mem_a[s1_slot_reg[VA_W-1:0]] <= s1_coord_reg;
            vert_mem_b[s1_slot_reg[VA_W-1:0]] <= s1_coord_reg;
            vert_mem_c[s1_slot_reg[VA_W-1:0]] <= s1_coord_reg;
        end
        if (en)
        begin
            rd_a_reg <= vert_mem_a[ca[VA_W-1:0]];
            rd_b_reg <= vert_mem_b[cb[VA_W-1:0]];
            rd_c_reg <= vert_mem_c[cc[VA_W-1:0]];
        end
    end

    always_comb
    begin
        flg2_next.query   = (s1_req_reg == REQ_QUERY);
        flg2_next.idx_err = !(s1_face_ok_reg && corner_ok(ca, vertex_count_reg)
                              && corner_ok(cb, vertex_count_reg)
                              && corner_ok(cc, vertex_count_reg));
        flg2_next.degen   = 1'b0;
        flg2_next.neg     = '0;
    end

    // Stages 3 to 9: edges, products, cross product, magnitudes,
    // shift count, scaled magnitudes, squares.
    logic signed [EDGE_W-1:0] e1_reg [3], e2_reg [3];
    logic signed [PROD_W-1:0] prod_reg [6];
    logic signed [MAG_W-1:0]  cross_reg [3];
    logic [MAG_W-1:0]         mag6_reg [3], mag7_reg [3], mag6_next [3];
    logic [MAG_W-1:0]         mag_or;
    logic [SH_W-1:0]          sh_reg, sh_next;
    logic [NORM_W-1:0]        norm8_reg [3], norm9_reg [3];
    logic [SQ_W-1:0]          sq_reg [3];

    always_comb
    begin
        flg6_next = flg_reg[5];
        for (int i = 0; i < 3; i++)
        begin
            flg6_next.neg[i] = cross_reg[i][MAG_W-1];
            mag6_next[i] = cross_reg[i][MAG_W-1] ? (~cross_reg[i] + 1'b1) : cross_reg[i];
        end
        flg6_next.degen = (cross_reg[0] == '0) && (cross_reg[1] == '0)
                          && (cross_reg[2] == '0);
    end

    // Smallest shift that brings the largest magnitude below 2^30.
    always_comb
    begin
        mag_or  = mag6_reg[0] | mag6_reg[1] | mag6_reg[2];
        sh_next = '0;
        for (int k = 0; k < SH_N; k++)
        begin
            sh_next = sh_next + SH_W'(|(mag_or >> (NORM_W + k)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg[2] <= flg2_next;
            for (int k = 3; k <= 9; k++)
            begin
                flg_reg[k] <= (k == 6) ? flg6_next : flg_reg[k-1];
            end
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i]    <= coord_ext(rd_b_reg, i) - coord_ext(rd_a_reg, i);
                e2_reg[i]    <= coord_ext(rd_c_reg, i) - coord_ext(rd_a_reg, i);
                cross_reg[i] <= $signed({prod_reg[2*i][PROD_W-1], prod_reg[2*i]})
                                - $signed({prod_reg[2*i+1][PROD_W-1], prod_reg[2*i+1]});
                mag6_reg[i]  <= mag6_next[i];
                mag7_reg[i]  <= mag6_reg[i];
                norm8_reg[i] <= NORM_W'(mag7_reg[i] >> sh_reg);
                sq_reg[i]    <= norm8_reg[i] * norm8_reg[i];
                norm9_reg[i] <= norm8_reg[i];
            end
            prod_reg[0] <= e1_reg[1] * e2_reg[2];
            prod_reg[1] <= e1_reg[2] * e2_reg[1];
            prod_reg[2] <= e1_reg[2] * e2_reg[0];
            prod_reg[3] <= e1_reg[0] * e2_reg[2];
            prod_reg[4] <= e1_reg[0] * e2_reg[1];
            prod_reg[5] <= e1_reg[1] * e2_reg[0];
            sh_reg      <= sh_next;
        end
    end

    // Square root, one result bit per stage.
    logic [SUM_W-1:0] sqx_reg [SQRT_STEPS+1];
    logic [SUM_W-1:0] sqr_reg [SQRT_STEPS+1];
    mg_vec_t          sqm_reg [SQRT_STEPS+1];
    flags_t           sqf_reg [SQRT_STEPS+1];
    logic [SQRT_STEPS:0] sqv_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg[0] <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sqr_reg[0] <= '0;
            sqf_reg[0] <= flg_reg[9];
            for (int i = 0; i < 3; i++)
            begin
                sqm_reg[0][i] <= norm9_reg[i];
            end
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [SUM_W:0] trial;
        logic           ge;

        assign trial = {1'b0, sqr_reg[k]} + {1'b0, BIT};
        assign ge    = {1'b0, sqx_reg[k]} >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqx_reg[k+1] <= ge ? (sqx_reg[k] - trial[SUM_W-1:0]) : sqx_reg[k];
                sqr_reg[k+1] <= ge ? ((sqr_reg[k] >> 1) + BIT) : (sqr_reg[k] >> 1);
                sqm_reg[k+1] <= sqm_reg[k];
                sqf_reg[k+1] <= sqf_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg <= '0;
        end
        else if (en)
        begin
            sqv_reg <= {sqv_reg[SQRT_STEPS-1:0], vld_reg[8]};
        end
    end

    // Divider: rounded quotient of each magnitude by the root, one bit a stage.
    logic [ROOT_W-1:0]  root, root_fix;
    logic [NUM_W-1:0]   dvrem_reg [DIV_STEPS+1][3];
    logic [QUO_W-1:0]   dvq_reg [DIV_STEPS+1][3];
    logic [ROOT_W-1:0]  dvd_reg [DIV_STEPS+1];
    flags_t             dvf_reg [DIV_STEPS+1];
    logic [DIV_STEPS:0] dvv_reg;

    assign root     = sqr_reg[SQRT_STEPS][ROOT_W-1:0];
    assign root_fix = (root == '0) ? ROOT_W'(1) : root;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg[0] <= root_fix;
            dvf_reg[0] <= sqf_reg[SQRT_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                dvrem_reg[0][i] <= (NUM_W'(sqm_reg[SQRT_STEPS][i]) << QFRAC)
                                   + NUM_W'(root_fix >> 1);
                dvq_reg[0][i]   <= '0;
            end
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int unsigned SH = DIV_STEPS - 1 - k;
        logic [NUM_W-1:0] dsh;

        assign dsh = NUM_W'(dvd_reg[k]) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvd_reg[k+1] <= dvd_reg[k];
                dvf_reg[k+1] <= dvf_reg[k];
                for (int i = 0; i < 3; i++)
                begin
                    if (dvrem_reg[k][i] >= dsh)
                    begin
                        dvrem_reg[k+1][i] <= dvrem_reg[k][i] - dsh;
                        dvq_reg[k+1][i]   <= dvq_reg[k][i] | (QUO_W'(1) << SH);
                    end
                    else
                    begin
                        dvrem_reg[k+1][i] <= dvrem_reg[k][i];
                        dvq_reg[k+1][i]   <= dvq_reg[k][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvv_reg <= '0;
        end
        else if (en)
        begin
            dvv_reg <= {dvv_reg[DIV_STEPS-1:0], sqv_reg[SQRT_STEPS]};
        end
    end

    // Final word: sign, and zeros for errors and degenerate faces.
    logic [OUT_W-1:0] comp [3];
    flags_t           fin_f;

    assign fin_f = dvf_reg[DIV_STEPS];
    assign emit  = en && dvv_reg[DIV_STEPS] && fin_f.query;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = {1'b0, dvq_reg[DIV_STEPS][i]};
            if (fin_f.neg[i])
            begin
                comp[i] = ~comp[i] + 1'b1;
            end
            if (fin_f.idx_err || fin_f.degen)
            begin
                comp[i] = '0;
            end
        end
        fin_word.normal_x    = comp[0];
        fin_word.normal_y    = comp[1];
        fin_word.normal_z    = comp[2];
        fin_word.degenerate  = fin_f.degen && !fin_f.idx_err;
        fin_word.index_error = fin_f.idx_err;
    end

    // Two-entry output buffer.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (!rsp_stall)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (emit)
        begin
            if (!out_valid_reg || !rsp_stall)
            begin
                out_next       = fin_word;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = fin_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

`ifndef ASSERT_OFF
    // The spare entry only fills behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("output buffer spare entry holds a word with the main entry empty");

    // Flagged results carry a zero normal, and index errors clear degenerate.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_word.index_error || rsp_word.degenerate) |->
        (rsp_word.normal_x == '0) && (rsp_word.normal_y == '0)
        && (rsp_word.normal_z == '0) && !(rsp_word.index_error && rsp_word.degenerate))
        else $error("flagged result with nonzero normal or both flags set");

    // A good normal is never all zeros.
    a_normal_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_word.index_error && !rsp_word.degenerate |->
        (rsp_word.normal_x != '0) || (rsp_word.normal_y != '0)
        || (rsp_word.normal_z != '0))
        else $error("unit normal came out as zero");

    // Components stay within unit range.
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |->
        (rsp_word.normal_x <= 16'sd16384) && (rsp_word.normal_x >= -16'sd16384)
        && (rsp_word.normal_y <= 16'sd16384) && (rsp_word.normal_y >= -16'sd16384)
        && (rsp_word.normal_z <= 16'sd16384) && (rsp_word.normal_z >= -16'sd16384))
        else $error("normal component outside unit range");
`endif

endmodule
